// ----- rtl/track_segment_light_sampler_defines.svh -----
// ---------------------------------------------------------------------------
// Track segment light sampler assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TRACK_SEGMENT_LIGHT_SAMPLER_DEFINES_SVH
`define TRACK_SEGMENT_LIGHT_SAMPLER_DEFINES_SVH

// cond holds -> conseq holds in the same cycle
`define TSLS_ASSERT_IMPL(label, cond, conseq, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
	else $error(msg);

// cond holds -> conseq holds in the next cycle
`define TSLS_ASSERT_NEXT(label, cond, conseq, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
	else $error(msg);

`endif

// ----- rtl/tsls_pkg.sv -----
// ---------------------------------------------------------------------------
// Track segment light sampler package
// Field widths, register codes and the controller/datapath command types.
// ---------------------------------------------------------------------------
package tsls_pkg;

	localparam int SEG_W        = 23;
	localparam int LY_W         = 20;
	localparam int DEDX_W       = 16;
	localparam int CHARGE_W     = 40;
	localparam int CHARGE_SHIFT = 18;
	localparam int MUL_A_W      = 36;
	localparam int MUL_B_W      = 18;
	localparam int ACC_W        = 72;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 23;
	localparam int AXES         = 3;

	localparam logic [SEG_W-1:0]  SEG_RESET = 23'd128;
	localparam logic [LY_W-1:0]   LY_RESET  = 20'd40000;
	localparam logic [DEDX_W-1:0] MIP_RESET = 16'd2120;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEGMENT_LENGTH = 2'd0,
		CFG_LIGHT_YIELD    = 2'd1,
		CFG_MIP_DEDX       = 2'd2
	} cfg_index_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DL,
		OP_MUL,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_SQRT_DONE,
		OP_WALK_INIT,
		OP_WALK_NEXT,
		OP_HALF,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_COORD,
		OP_CHARGE,
		OP_OUT
	} op_t;

	typedef enum logic {
		A_ABS_D,
		A_DL
	} mul_a_t;

	typedef enum logic [2:0] {
		B_ABS_D,
		B_DIST,
		B_GAP,
		B_WEIGHT,
		B_T2,
		B_T2_REM
	} mul_b_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] axis;
		mul_a_t     a_sel;
		mul_b_t     b_sel;
		logic       half;
		logic       clr;
		logic       last;
	} dp_cmd_t;

	typedef struct packed {
		logic prev_valid;
		logic short_seg;
		logic more;
		logic out_busy;
	} dp_status_t;

endpackage

// ----- rtl/tsls_datapath.sv -----
// ---------------------------------------------------------------------------
// Track segment light sampler datapath
// Point registers, shared multiplier/accumulator, bit-serial square root and
// divider, sub-segment walk and the result register.
// ---------------------------------------------------------------------------
module tsls_datapath #(
	parameter int COORD_BITS   = 24,
	parameter int MAX_SEGMENTS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tsls_pkg::dp_cmd_t                    cmd,
	output tsls_pkg::dp_status_t                 status,
	input  logic                                 cfg_wr_en,
	input  logic [tsls_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tsls_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic signed [COORD_BITS-1:0]         pos_x,
	input  logic signed [COORD_BITS-1:0]         pos_y,
	input  logic signed [COORD_BITS-1:0]         pos_z,
	input  logic [tsls_pkg::DEDX_W-1:0]          energy_loss,
	input  logic                                 use_mip,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [COORD_BITS-1:0]         mid_x,
	output logic signed [COORD_BITS-1:0]         mid_y,
	output logic signed [COORD_BITS-1:0]         mid_z,
	output logic [tsls_pkg::CHARGE_W-1:0]        charge,
	output logic                                 last,
	output logic                                 truncated
);

	localparam int C      = COORD_BITS;
	localparam int DIST_W = C + 2;
	localparam int T2_W   = C + 4;
	localparam int Q_W    = C + 1;
	localparam int REM_W  = DIST_W + 1;
	localparam int NUM_W  = Q_W + REM_W;
	localparam int SQ_W   = 2 * DIST_W;
	localparam int MAX_W  = $clog2(MAX_SEGMENTS + 1);
	localparam int LIM_W  = tsls_pkg::SEG_W + MAX_W;
	localparam int CMP_W  = (T2_W > LIM_W) ? T2_W : LIM_W;
	localparam int PROD_W = tsls_pkg::MUL_A_W + tsls_pkg::MUL_B_W;

	logic [tsls_pkg::SEG_W-1:0]   seg_q;
	logic [tsls_pkg::LY_W-1:0]    ly_q;
	logic [tsls_pkg::DEDX_W-1:0]  mip_q;

	logic signed [C-1:0] pos_in [tsls_pkg::AXES];
	logic signed [C-1:0] prev_q [tsls_pkg::AXES];
	logic signed [C-1:0] new_q  [tsls_pkg::AXES];
	logic signed [C:0]   d_q    [tsls_pkg::AXES];
	logic                prev_valid_q;

	logic [tsls_pkg::DEDX_W-1:0]  dedx_q;
	logic [tsls_pkg::MUL_A_W-1:0] dl_q;
	logic [tsls_pkg::ACC_W-1:0]   acc_q;
	logic [SQ_W-1:0]              res_q;
	logic [SQ_W-1:0]              one_q;
	logic [DIST_W-1:0]            dist_q;
	logic [DIST_W-1:0]            wrem_q;
	logic [T2_W-1:0]              t2_q;
	logic                         short_q;
	logic                         trunc_q;
	logic [REM_W-1:0]             rem_q;
	logic [Q_W-1:0]               quo_q;

	logic signed [C-1:0]          st_q [tsls_pkg::AXES];
	logic [tsls_pkg::CHARGE_W-1:0] st_charge_q;

	logic signed [C-1:0]          mid_q [tsls_pkg::AXES];
	logic [tsls_pkg::CHARGE_W-1:0] charge_q;
	logic                         last_q;
	logic                         trunc_out_q;
	logic                         out_valid_q;

	logic [tsls_pkg::SEG_W-1:0]   gap;
	logic [CMP_W-1:0]             gap_c;
	logic [CMP_W-1:0]             dist_c;
	logic [CMP_W-1:0]             wrem_c;
	logic [CMP_W-1:0]             lim_c;
	logic [C:0]                   d_u;
	logic [C:0]                   abs_d;
	logic [T2_W-1:0]              t2_rem;
	logic [tsls_pkg::MUL_A_W-1:0] mul_a;
	logic [tsls_pkg::MUL_A_W-1:0] b_full;
	logic [tsls_pkg::MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]            prod;
	logic [tsls_pkg::ACC_W-1:0]   prod_sh;
	logic [tsls_pkg::ACC_W-1:0]   acc_base;
	logic [SQ_W-1:0]              trial;
	logic                         sq_ge;
	logic [NUM_W-1:0]             num;
	logic [REM_W:0]               div_t;
	logic [REM_W:0]               div_d;
	logic [REM_W:0]               div_sub;
	logic                         div_ge;
	logic signed [C-1:0]          new_sel;
	logic [C:0]                   coord_sum;
	logic signed [C-1:0]          half_v [tsls_pkg::AXES];
	logic signed [C+1:0]          half_sum [tsls_pkg::AXES];
	logic                         charge_over;
	logic [tsls_pkg::CHARGE_W-1:0] charge_v;

	assign pos_in[0] = pos_x;
	assign pos_in[1] = pos_y;
	assign pos_in[2] = pos_z;

	always_comb begin
		gap    = (seg_q == '0) ? tsls_pkg::SEG_W'(1) : seg_q;
		gap_c  = CMP_W'(gap);
		dist_c = CMP_W'(dist_q);
		wrem_c = CMP_W'(wrem_q);
		lim_c  = gap_c * CMP_W'(MAX_SEGMENTS);
		d_u    = d_q[cmd.axis];
		abs_d  = d_u[C] ? (~d_u + (C+1)'(1)) : d_u;
		t2_rem = t2_q + T2_W'(wrem_q) - gap_c[T2_W-1:0];

		mul_a = (cmd.a_sel == tsls_pkg::A_DL) ? dl_q : tsls_pkg::MUL_A_W'(abs_d);
		case (cmd.b_sel)
			tsls_pkg::B_ABS_D:  b_full = tsls_pkg::MUL_A_W'(abs_d);
			tsls_pkg::B_DIST:   b_full = tsls_pkg::MUL_A_W'(dist_q);
			tsls_pkg::B_GAP:    b_full = tsls_pkg::MUL_A_W'(gap);
			tsls_pkg::B_WEIGHT: b_full = tsls_pkg::MUL_A_W'(wrem_q);
			tsls_pkg::B_T2:     b_full = tsls_pkg::MUL_A_W'(t2_q);
			tsls_pkg::B_T2_REM: b_full = tsls_pkg::MUL_A_W'(t2_rem);
			default:            b_full = '0;
		endcase
		mul_b = cmd.half ? b_full[2*tsls_pkg::MUL_B_W-1:tsls_pkg::MUL_B_W]
		                 : b_full[tsls_pkg::MUL_B_W-1:0];
		prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
		prod_sh  = cmd.half ? (tsls_pkg::ACC_W'(prod) << tsls_pkg::MUL_B_W)
		                    : tsls_pkg::ACC_W'(prod);
		acc_base = cmd.clr ? '0 : acc_q;

		trial = res_q + one_q;
		sq_ge = acc_q[SQ_W-1:0] >= trial;

		num     = acc_q[NUM_W-1:0] + NUM_W'(dist_q);
		div_t   = {rem_q, quo_q[Q_W-1]};
		div_d   = (REM_W+1)'({dist_q, 1'b0});
		div_sub = div_t - div_d;
		div_ge  = div_t >= div_d;

		new_sel   = new_q[cmd.axis];
		coord_sum = d_u[C] ? ({new_sel[C-1], new_sel} - quo_q)
		                   : ({new_sel[C-1], new_sel} + quo_q);

		for (int i = 0; i < tsls_pkg::AXES; i++) begin
			half_sum[i] = {{2{new_q[i][C-1]}}, new_q[i]} + {{2{new_q[i][C-1]}}, new_q[i]}
			            + {d_q[i][C], d_q[i]};
			half_v[i]   = half_sum[i][C:1];
		end

		charge_over = |acc_q[tsls_pkg::ACC_W-1:tsls_pkg::CHARGE_SHIFT+tsls_pkg::CHARGE_W];
		charge_v    = charge_over ? '1 : acc_q[tsls_pkg::CHARGE_SHIFT +: tsls_pkg::CHARGE_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= tsls_pkg::SEG_RESET;
			ly_q  <= tsls_pkg::LY_RESET;
			mip_q <= tsls_pkg::MIP_RESET;
		end else if (cfg_wr_en) begin
			case (tsls_pkg::cfg_index_t'(cfg_index))
				tsls_pkg::CFG_SEGMENT_LENGTH: seg_q <= cfg_data[tsls_pkg::SEG_W-1:0];
				tsls_pkg::CFG_LIGHT_YIELD:    ly_q  <= cfg_data[tsls_pkg::LY_W-1:0];
				tsls_pkg::CFG_MIP_DEDX:       mip_q <= cfg_data[tsls_pkg::DEDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < tsls_pkg::AXES; i++) begin
				prev_q[i] <= '0;
			end
		end else begin
			if (cmd.op == tsls_pkg::OP_LOAD) begin
				prev_valid_q <= 1'b1;
				for (int i = 0; i < tsls_pkg::AXES; i++) begin
					prev_q[i] <= pos_in[i];
				end
			end
			if (cmd.op == tsls_pkg::OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			tsls_pkg::OP_LOAD: begin
				for (int i = 0; i < tsls_pkg::AXES; i++) begin
					new_q[i] <= pos_in[i];
					d_q[i]   <= {prev_q[i][C-1], prev_q[i]} - {pos_in[i][C-1], pos_in[i]};
				end
				dedx_q <= use_mip ? mip_q : energy_loss;
			end
			tsls_pkg::OP_DL: begin
				dl_q <= tsls_pkg::MUL_A_W'(dedx_q) * tsls_pkg::MUL_A_W'(ly_q);
			end
			tsls_pkg::OP_MUL: begin
				acc_q <= acc_base + prod_sh;
			end
			tsls_pkg::OP_SQRT_INIT: begin
				res_q <= '0;
				one_q <= SQ_W'(1) << (SQ_W - 2);
			end
			tsls_pkg::OP_SQRT_STEP: begin
				if (sq_ge) begin
					acc_q <= tsls_pkg::ACC_W'(acc_q[SQ_W-1:0] - trial);
					res_q <= (res_q >> 1) + one_q;
				end else begin
					res_q <= res_q >> 1;
				end
				one_q <= one_q >> 2;
			end
			tsls_pkg::OP_SQRT_DONE: begin
				dist_q <= res_q[DIST_W-1:0];
			end
			tsls_pkg::OP_WALK_INIT: begin
				wrem_q  <= dist_q;
				t2_q    <= gap_c[T2_W-1:0];
				short_q <= dist_c <= gap_c;
				trunc_q <= dist_c >= lim_c;
			end
			tsls_pkg::OP_WALK_NEXT: begin
				wrem_q <= wrem_q - gap_c[DIST_W-1:0];
				t2_q   <= t2_q + {gap_c[T2_W-2:0], 1'b0};
			end
			tsls_pkg::OP_HALF: begin
				for (int i = 0; i < tsls_pkg::AXES; i++) begin
					st_q[i] <= half_v[i];
				end
			end
			tsls_pkg::OP_DIV_INIT: begin
				rem_q <= num[NUM_W-1:Q_W];
				quo_q <= num[Q_W-1:0];
			end
			tsls_pkg::OP_DIV_STEP: begin
				rem_q <= div_ge ? div_sub[REM_W-1:0] : div_t[REM_W-1:0];
				quo_q <= {quo_q[Q_W-2:0], div_ge};
			end
			tsls_pkg::OP_COORD: begin
				st_q[cmd.axis] <= coord_sum[C-1:0];
			end
			tsls_pkg::OP_CHARGE: begin
				st_charge_q <= charge_v;
			end
			tsls_pkg::OP_OUT: begin
				for (int i = 0; i < tsls_pkg::AXES; i++) begin
					mid_q[i] <= st_q[i];
				end
				charge_q    <= st_charge_q;
				last_q      <= cmd.last;
				trunc_out_q <= trunc_q;
			end
			default: ;
		endcase
	end

	assign status.prev_valid = prev_valid_q;
	assign status.short_seg  = short_q;
	assign status.more       = wrem_c >= gap_c;
	assign status.out_busy   = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign mid_x     = mid_q[0];
	assign mid_y     = mid_q[1];
	assign mid_z     = mid_q[2];
	assign charge    = charge_q;
	assign last      = last_q;
	assign truncated = trunc_out_q;

endmodule

// ----- rtl/tsls_ctrl.sv -----
// ---------------------------------------------------------------------------
// Track segment light sampler controller
// Sequences the datapath through length, walk, midpoint and charge steps.
// ---------------------------------------------------------------------------
module tsls_ctrl #(
	parameter int COORD_BITS   = 24,
	parameter int MAX_SEGMENTS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 track_start,
	output logic                 in_ready,
	input  tsls_pkg::dp_status_t status,
	output tsls_pkg::dp_cmd_t    cmd
);

	localparam int DIST_W = COORD_BITS + 2;
	localparam int Q_W    = COORD_BITS + 1;
	localparam int CW     = $clog2(DIST_W + 1);
	localparam int KW     = $clog2(MAX_SEGMENTS);
	localparam logic [KW-1:0] KMAX = KW'(MAX_SEGMENTS - 1);

	typedef enum logic [16:0] {
		S_IDLE = 17'd1,
		S_DL   = 17'd2,
		S_SQ   = 17'd4,
		S_SQI  = 17'd8,
		S_SQS  = 17'd16,
		S_SQD  = 17'd32,
		S_WI   = 17'd64,
		S_SEL  = 17'd128,
		S_HALF = 17'd256,
		S_TM   = 17'd512,
		S_DVI  = 17'd1024,
		S_DVS  = 17'd2048,
		S_CRD  = 17'd4096,
		S_CM   = 17'd8192,
		S_CHG  = 17'd16384,
		S_OUTW = 17'd32768,
		S_NXT  = 17'd65536
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [1:0]    axis_q;
	logic          half_q;
	logic [KW-1:0] k_q;
	logic          full_q;
	logic          final_res;

	assign final_res = status.short_seg || !full_q;

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		cmd.op    = tsls_pkg::OP_NONE;
		cmd.axis  = axis_q;
		cmd.a_sel = tsls_pkg::A_ABS_D;
		cmd.b_sel = tsls_pkg::B_ABS_D;
		cmd.half  = half_q;
		cmd.clr   = 1'b0;
		cmd.last  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = tsls_pkg::OP_LOAD;
					if (!track_start && status.prev_valid) begin
						state_d = S_DL;
					end
				end
			end
			S_DL: begin
				cmd.op  = tsls_pkg::OP_DL;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.op  = tsls_pkg::OP_MUL;
				cmd.clr = (axis_q == 2'd0) && !half_q;
				if (axis_q == 2'd2 && half_q) begin
					state_d = S_SQI;
				end
			end
			S_SQI: begin
				cmd.op  = tsls_pkg::OP_SQRT_INIT;
				state_d = S_SQS;
			end
			S_SQS: begin
				cmd.op = tsls_pkg::OP_SQRT_STEP;
				if (cnt_q == CW'(DIST_W - 1)) begin
					state_d = S_SQD;
				end
			end
			S_SQD: begin
				cmd.op  = tsls_pkg::OP_SQRT_DONE;
				state_d = S_WI;
			end
			S_WI: begin
				cmd.op  = tsls_pkg::OP_WALK_INIT;
				state_d = S_SEL;
			end
			S_SEL: begin
				state_d = status.short_seg ? S_HALF : S_TM;
			end
			S_HALF: begin
				cmd.op  = tsls_pkg::OP_HALF;
				state_d = S_CM;
			end
			S_TM: begin
				cmd.op    = tsls_pkg::OP_MUL;
				cmd.b_sel = full_q ? tsls_pkg::B_T2 : tsls_pkg::B_T2_REM;
				cmd.clr   = !half_q;
				if (half_q) begin
					state_d = S_DVI;
				end
			end
			S_DVI: begin
				cmd.op  = tsls_pkg::OP_DIV_INIT;
				state_d = S_DVS;
			end
			S_DVS: begin
				cmd.op = tsls_pkg::OP_DIV_STEP;
				if (cnt_q == CW'(Q_W - 1)) begin
					state_d = S_CRD;
				end
			end
			S_CRD: begin
				cmd.op  = tsls_pkg::OP_COORD;
				state_d = (axis_q == 2'd2) ? S_CM : S_TM;
			end
			S_CM: begin
				cmd.op    = tsls_pkg::OP_MUL;
				cmd.a_sel = tsls_pkg::A_DL;
				if (status.short_seg) begin
					cmd.b_sel = tsls_pkg::B_DIST;
				end else if (full_q) begin
					cmd.b_sel = tsls_pkg::B_GAP;
				end else begin
					cmd.b_sel = tsls_pkg::B_WEIGHT;
				end
				cmd.clr = !half_q;
				if (half_q) begin
					state_d = S_CHG;
				end
			end
			S_CHG: begin
				cmd.op  = tsls_pkg::OP_CHARGE;
				state_d = S_OUTW;
			end
			S_OUTW: begin
				if (!status.out_busy) begin
					cmd.op   = tsls_pkg::OP_OUT;
					cmd.last = final_res;
					state_d  = final_res ? S_IDLE : S_NXT;
				end
			end
			S_NXT: begin
				cmd.op  = tsls_pkg::OP_WALK_NEXT;
				state_d = S_SEL;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			axis_q  <= '0;
			half_q  <= 1'b0;
			k_q     <= '0;
			full_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					axis_q <= '0;
					half_q <= 1'b0;
					k_q    <= '0;
				end
				S_SQ: begin
					half_q <= ~half_q;
					if (half_q) begin
						axis_q <= axis_q + 2'd1;
					end
				end
				S_SQI: begin
					axis_q <= '0;
					cnt_q  <= '0;
				end
				S_SQS: begin
					cnt_q <= (cnt_q == CW'(DIST_W - 1)) ? '0 : cnt_q + CW'(1);
				end
				S_SEL: begin
					full_q <= status.more && (k_q < KMAX);
					axis_q <= '0;
					half_q <= 1'b0;
				end
				S_TM: begin
					half_q <= ~half_q;
				end
				S_DVI: begin
					cnt_q <= '0;
				end
				S_DVS: begin
					cnt_q <= (cnt_q == CW'(Q_W - 1)) ? '0 : cnt_q + CW'(1);
				end
				S_CRD: begin
					axis_q <= axis_q + 2'd1;
				end
				S_CM: begin
					half_q <= ~half_q;
				end
				S_NXT: begin
					k_q <= k_q + KW'(1);
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/track_segment_light_sampler.sv -----
// ---------------------------------------------------------------------------
// Track segment light sampler
// Splits each track step into sub-segments and gives midpoint and photon
// charge for each one.
// ---------------------------------------------------------------------------
// Operation: a point with track_start (or the first after reset) is only stored
// and gives no result. For any other point the bit-serial square root
// dominates the length computation. A short step then gives a single result;
// a longer step gives one result per sub-segment, each computed by running
// the one-bit-per-cycle divider once per axis. A new point is taken only
// after the last result of the previous one has been loaded into the output
// register; the output register holds a result until its transfer while the
// next result is computed.
`include "track_segment_light_sampler_defines.svh"

module track_segment_light_sampler #(
	parameter int COORD_BITS   = 24,
	parameter int MAX_SEGMENTS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [tsls_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsls_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [COORD_BITS-1:0]    pos_x,
	input  logic signed [COORD_BITS-1:0]    pos_y,
	input  logic signed [COORD_BITS-1:0]    pos_z,
	input  logic                            track_start,
	input  logic [tsls_pkg::DEDX_W-1:0]     energy_loss,
	input  logic                            use_mip,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [COORD_BITS-1:0]    mid_x,
	output logic signed [COORD_BITS-1:0]    mid_y,
	output logic signed [COORD_BITS-1:0]    mid_z,
	output logic [tsls_pkg::CHARGE_W-1:0]   charge,
	output logic                            last,
	output logic                            truncated
);

	tsls_pkg::dp_cmd_t    cmd;
	tsls_pkg::dp_status_t status;

	tsls_ctrl #(
		.COORD_BITS  (COORD_BITS),
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.track_start(track_start),
		.in_ready   (in_ready),
		.status     (status),
		.cmd        (cmd)
	);

	tsls_datapath #(
		.COORD_BITS  (COORD_BITS),
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.energy_loss(energy_loss),
		.use_mip    (use_mip),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.mid_x      (mid_x),
		.mid_y      (mid_y),
		.mid_z      (mid_z),
		.charge     (charge),
		.last       (last),
		.truncated  (truncated)
	);

	`TSLS_ASSERT_IMPL(a_no_overwrite, cmd.op == tsls_pkg::OP_OUT, !(out_valid && !out_ready), "result register overwritten before transfer")
	`TSLS_ASSERT_NEXT(a_start_no_work, in_valid && in_ready && track_start, in_ready, "track start point left the controller busy")
	`TSLS_ASSERT_IMPL(a_busy_mid_item, out_valid && !last, !in_ready, "point taken while results of the previous one are pending")

endmodule
